[hw/rtl/skct_pkg.sv]
// ----------------------------------------------------------------------------
// skct_pkg
// Shared types and constants for the sorted keyed count table.
// ----------------------------------------------------------------------------
package skct_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int AMOUNT_W    = 32;
  localparam int ENTRY_W     = KEY_W + AMOUNT_W;

  localparam logic signed [AMOUNT_W-1:0] AMOUNT_MAX = {1'b0, {(AMOUNT_W-1){1'b1}}};
  localparam logic signed [AMOUNT_W-1:0] AMOUNT_MIN = {1'b1, {(AMOUNT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_DUPLICATE = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_READ     = 9'b000000010,
    ST_CHECK    = 9'b000000100,
    ST_SHIFT_RD = 9'b000001000,
    ST_SHIFT_WR = 9'b000010000,
    ST_PLACE    = 9'b000100000,
    ST_UPDATE   = 9'b001000000,
    ST_DUMP     = 9'b010000000,
    ST_RESP     = 9'b100000000
  } state_t;

endpackage

[hw/rtl/skct_if.sv]
// ----------------------------------------------------------------------------
// skct_if
// Request and result channels of the sorted keyed count table.
// ----------------------------------------------------------------------------
interface skct_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic signed [31:0] item_key;
  logic signed [31:0] initial_amount;
  logic signed [31:0] amount_delta;

  modport source (output valid, kind, item_key, initial_amount, amount_delta,
                  input ready);
  modport sink   (input valid, kind, item_key, initial_amount, amount_delta,
                  output ready);
endinterface

interface skct_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [31:0] entry_key;
  logic signed [31:0] entry_amount;
  logic               last_of_run;

  modport source (output valid, status, entry_key, entry_amount, last_of_run,
                  input ready);
  modport sink   (input valid, status, entry_key, entry_amount, last_of_run,
                  output ready);
endinterface

[hw/rtl/skct_ram.sv]
// ----------------------------------------------------------------------------
// skct_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module skct_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/sorted_keyed_count_table.sv]
// search and update scan the entries from slot 0 up to the slot of the key;
// insert scans up to its slot, then shifts each later entry up with one read
// and one write; dump reads out the entries in key order.
// one request at a time: the request channel is ready only while idle.
// reset (rst_n, synchronous) empties the table at once; RAM contents are kept.
// ----------------------------------------------------------------------------
// sorted_keyed_count_table
// Key-ordered table of signed quantities with insert, search, update, dump.
// ----------------------------------------------------------------------------
module sorted_keyed_count_table import skct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  skct_in_if.sink     in_chan,
  skct_out_if.source  out_chan
);

  state_t                      state_r, state_nxt;
  kind_t                       kind_r, kind_nxt;
  logic signed [KEY_W-1:0]     key_r, key_nxt;
  logic signed [AMOUNT_W-1:0]  init_r, init_nxt;
  logic signed [AMOUNT_W-1:0]  delta_r, delta_nxt;
  logic        [CNT_W-1:0]     ptr_r, ptr_nxt;
  logic        [CNT_W-1:0]     ins_r, ins_nxt;
  logic        [CNT_W-1:0]     cnt_r, cnt_nxt;
  status_t                     res_status_r, res_status_nxt;
  logic signed [KEY_W-1:0]     res_key_r, res_key_nxt;
  logic signed [AMOUNT_W-1:0]  res_amount_r, res_amount_nxt;

  logic                        out_valid_r;
  status_t                     out_status_r;
  logic signed [KEY_W-1:0]     out_key_r;
  logic signed [AMOUNT_W-1:0]  out_amount_r;
  logic                        out_last_r;

  logic                        out_load;
  status_t                     ol_status;
  logic signed [KEY_W-1:0]     ol_key;
  logic signed [AMOUNT_W-1:0]  ol_amount;
  logic                        ol_last;

  logic                        ram_wr_en;
  logic        [ADDR_W-1:0]    ram_wr_addr;
  logic        [ENTRY_W-1:0]   ram_wr_data;
  logic                        ram_rd_en;
  logic        [ADDR_W-1:0]    ram_rd_addr;
  logic        [ENTRY_W-1:0]   ram_rd_data;

  logic signed [KEY_W-1:0]     rd_key;
  logic signed [AMOUNT_W-1:0]  rd_amount;
  logic signed [AMOUNT_W:0]    sum_w;
  logic signed [AMOUNT_W-1:0]  sat_w;
  logic        [CNT_W-1:0]     ptr_dec;
  logic        [CNT_W-1:0]     ptr_inc;
  logic                        at_last;
  logic                        in_fire;
  logic                        out_free;

  skct_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_key    = ram_rd_data[ENTRY_W-1:AMOUNT_W];
  assign rd_amount = ram_rd_data[AMOUNT_W-1:0];
  assign sum_w     = {rd_amount[AMOUNT_W-1], rd_amount} + {delta_r[AMOUNT_W-1], delta_r};
  assign sat_w     = (sum_w[AMOUNT_W] != sum_w[AMOUNT_W-1])
                     ? (sum_w[AMOUNT_W] ? AMOUNT_MIN : AMOUNT_MAX)
                     : sum_w[AMOUNT_W-1:0];
  assign ptr_dec   = ptr_r - CNT_W'(1);
  assign ptr_inc   = ptr_r + CNT_W'(1);
  assign at_last   = (ptr_inc == cnt_r);

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.entry_key    = out_key_r;
  assign out_chan.entry_amount = out_amount_r;
  assign out_chan.last_of_run  = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    init_nxt       = init_r;
    delta_nxt      = delta_r;
    ptr_nxt        = ptr_r;
    ins_nxt        = ins_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_amount_nxt = res_amount_r;
    out_load       = 1'b0;
    ol_status      = res_status_r;
    ol_key         = res_key_r;
    ol_amount      = res_amount_r;
    ol_last        = 1'b1;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = ptr_r[ADDR_W-1:0];
    ram_wr_data    = {key_r, init_r};
    ram_rd_en      = 1'b0;
    ram_rd_addr    = ptr_r[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt  = kind_t'(in_chan.kind);
          key_nxt   = in_chan.item_key;
          init_nxt  = in_chan.initial_amount;
          delta_nxt = in_chan.amount_delta;
          ptr_nxt   = '0;
          case (kind_t'(in_chan.kind))
            KIND_INSERT: begin
              if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
                res_status_nxt = STS_FULL;
                res_key_nxt    = in_chan.item_key;
                res_amount_nxt = '0;
                state_nxt      = ST_RESP;
              end else if (cnt_r == '0) begin
                state_nxt = ST_PLACE;
              end else begin
                state_nxt = ST_READ;
              end
            end
            KIND_DUMP: begin
              if (cnt_r == '0) begin
                res_status_nxt = STS_EMPTY;
                res_key_nxt    = '0;
                res_amount_nxt = '0;
                state_nxt      = ST_RESP;
              end else begin
                state_nxt = ST_READ;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                res_status_nxt = STS_NOT_FOUND;
                res_key_nxt    = in_chan.item_key;
                res_amount_nxt = '0;
                state_nxt      = ST_RESP;
              end else begin
                state_nxt = ST_READ;
              end
            end
          endcase
        end
      end

      ST_READ: begin
        ram_rd_en = 1'b1;
        state_nxt = (kind_r == KIND_DUMP) ? ST_DUMP : ST_CHECK;
      end

      ST_CHECK: begin
        res_key_nxt = key_r;
        if (rd_key == key_r) begin
          res_amount_nxt = rd_amount;
          case (kind_r)
            KIND_INSERT: begin
              res_status_nxt = STS_DUPLICATE;
              state_nxt      = ST_RESP;
            end
            KIND_UPDATE: begin
              state_nxt = ST_UPDATE;
            end
            default: begin
              res_status_nxt = STS_OK;
              state_nxt      = ST_RESP;
            end
          endcase
        end else if (rd_key > key_r) begin
          if (kind_r == KIND_INSERT) begin
            ins_nxt   = ptr_r;
            ptr_nxt   = cnt_r;
            state_nxt = ST_SHIFT_RD;
          end else begin
            res_status_nxt = STS_NOT_FOUND;
            res_amount_nxt = '0;
            state_nxt      = ST_RESP;
          end
        end else if (at_last) begin
          if (kind_r == KIND_INSERT) begin
            ptr_nxt   = cnt_r;
            state_nxt = ST_PLACE;
          end else begin
            res_status_nxt = STS_NOT_FOUND;
            res_amount_nxt = '0;
            state_nxt      = ST_RESP;
          end
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = ST_READ;
        end
      end

      ST_SHIFT_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = ptr_dec[ADDR_W-1:0];
        state_nxt   = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = ram_rd_data;
        ptr_nxt     = ptr_dec;
        state_nxt   = (ptr_dec == ins_r) ? ST_PLACE : ST_SHIFT_RD;
      end

      ST_PLACE: begin
        ram_wr_en      = 1'b1;
        cnt_nxt        = cnt_r + CNT_W'(1);
        res_status_nxt = STS_OK;
        res_key_nxt    = key_r;
        res_amount_nxt = init_r;
        state_nxt      = ST_RESP;
      end

      ST_UPDATE: begin
        ram_wr_en      = 1'b1;
        ram_wr_data    = {key_r, sat_w};
        res_status_nxt = STS_OK;
        res_key_nxt    = key_r;
        res_amount_nxt = sat_w;
        state_nxt      = ST_RESP;
      end

      ST_DUMP: begin
        if (out_free) begin
          out_load  = 1'b1;
          ol_status = STS_OK;
          ol_key    = rd_key;
          ol_amount = rd_amount;
          ol_last   = at_last;
          if (at_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_inc;
            state_nxt = ST_READ;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    init_r       <= init_nxt;
    delta_r      <= delta_nxt;
    ptr_r        <= ptr_nxt;
    ins_r        <= ins_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_amount_r <= res_amount_nxt;
    if (out_load) begin
      out_status_r <= ol_status;
      out_key_r    <= ol_key;
      out_amount_r <= ol_amount;
      out_last_r   <= ol_last;
    end
  end

  // table never overfills
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // each placed entry grows the table by one
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PLACE |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("entry count not advanced by insert");

  // shifting never runs below the insertion slot
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT_WR |-> ptr_r > ins_r)
    else $error("shift pointer below insertion slot");

  // a result is only loaded into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(out_key_r))
    else $error("pending result overwritten");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, search, update and dump requests into the sorted keyed count
// table and keeps its own mirror of the table to work out every result. The
// run covers edge keys and quantities, saturation, duplicates, empty and full
// tables, and a random request mix under changing sender and receiver idling.
// Results are compared field by field and in order.
// ----------------------------------------------------------------------------
module tb_top;
  import skct_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    status_t            status;
    logic signed [31:0] key;
    logic signed [31:0] amount;
    logic               last;
  } outcome_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  skct_in_if  in_chan ();
  skct_out_if out_chan ();

  sorted_keyed_count_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  logic signed [31:0] mirror_key    [TABLE_DEPTH];
  logic signed [31:0] mirror_amount [TABLE_DEPTH];
  int                 mirror_count;
  outcome_t           outcome_queue [$];

  int          error_count;
  int          requests_sent;
  int          results_checked;
  int          dumps_sent;
  int          full_refusals;
  int          peak_fill;
  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned cycle_count;

  task automatic report_error(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic int mirror_find(input logic signed [31:0] key);
    for (int i = 0; i < mirror_count; i++)
      if (mirror_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void queue_outcome(input status_t st, input logic signed [31:0] key,
                                        input logic signed [31:0] amount, input logic last);
    outcome_t o;
    o.status = st;
    o.key    = key;
    o.amount = amount;
    o.last   = last;
    outcome_queue.push_back(o);
  endfunction

  function automatic void compute_table_outcome(input kind_t kind,
                                                input logic signed [31:0] key,
                                                input logic signed [31:0] init,
                                                input logic signed [31:0] delta);
    int     pos;
    int     slot;
    longint sum;
    pos = mirror_find(key);
    case (kind)
      KIND_INSERT: begin
        if (mirror_count >= TABLE_DEPTH) begin
          full_refusals++;
          queue_outcome(STS_FULL, key, '0, 1'b1);
        end else if (pos >= 0) begin
          queue_outcome(STS_DUPLICATE, key, mirror_amount[pos], 1'b1);
        end else begin
          slot = 0;
          while (slot < mirror_count && mirror_key[slot] < key) slot++;
          for (int j = mirror_count; j > slot; j--) begin
            mirror_key[j]    = mirror_key[j-1];
            mirror_amount[j] = mirror_amount[j-1];
          end
          mirror_key[slot]    = key;
          mirror_amount[slot] = init;
          mirror_count++;
          if (mirror_count > peak_fill) peak_fill = mirror_count;
          queue_outcome(STS_OK, key, init, 1'b1);
        end
      end
      KIND_SEARCH, KIND_UPDATE: begin
        if (pos < 0) begin
          queue_outcome(STS_NOT_FOUND, key, '0, 1'b1);
        end else begin
          if (kind == KIND_UPDATE) begin
            sum = longint'(mirror_amount[pos]) + longint'(delta);
            if (sum > longint'(AMOUNT_MAX)) sum = longint'(AMOUNT_MAX);
            else if (sum < longint'(AMOUNT_MIN)) sum = longint'(AMOUNT_MIN);
            mirror_amount[pos] = sum[31:0];
          end
          queue_outcome(STS_OK, key, mirror_amount[pos], 1'b1);
        end
      end
      default: begin
        if (mirror_count == 0) begin
          queue_outcome(STS_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < mirror_count; i++)
            queue_outcome(STS_OK, mirror_key[i], mirror_amount[i], i == mirror_count - 1);
        end
      end
    endcase
  endfunction

  task automatic send_request(input kind_t kind, input logic signed [31:0] key,
                              input logic signed [31:0] init,
                              input logic signed [31:0] delta);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.kind           <= kind;
    in_chan.item_key       <= key;
    in_chan.initial_amount <= init;
    in_chan.amount_delta   <= delta;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    compute_table_outcome(kind, key, init, delta);
    requests_sent++;
    if (kind == KIND_DUMP) dumps_sent++;
  endtask

  function automatic logic signed [31:0] pick_known_key();
    if (mirror_count == 0) return $urandom;
    return mirror_key[$urandom_range(0, mirror_count - 1)];
  endfunction

  function automatic logic signed [31:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return AMOUNT_MAX;
      1:       return AMOUNT_MIN;
      2:       return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // results leave in request order, one table operation at a time
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_checked++;
      if (outcome_queue.size() == 0) begin
        report_error($sformatf("unexpected result status %0d key %0d amount %0d last %0b",
                               out_chan.status, out_chan.entry_key, out_chan.entry_amount,
                               out_chan.last_of_run));
      end else begin
        want = outcome_queue.pop_front();
        if (out_chan.status !== want.status)
          report_error($sformatf("status got %0d want %0d (key %0d)",
                                 out_chan.status, want.status, want.key));
        if (out_chan.entry_key !== want.key)
          report_error($sformatf("entry_key got %0d want %0d",
                                 out_chan.entry_key, want.key));
        if (out_chan.entry_amount !== want.amount)
          report_error($sformatf("entry_amount got %0d want %0d (key %0d)",
                                 out_chan.entry_amount, want.amount, want.key));
        if (out_chan.last_of_run !== want.last)
          report_error($sformatf("last_of_run got %0b want %0b (key %0d)",
                                 out_chan.last_of_run, want.last, want.key));
      end
    end
  end

  always @(negedge clk) out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, outcome_queue.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed_cases();
    set_idling(0, 0);
    send_request(KIND_DUMP,   $urandom,   $urandom,   $urandom);
    send_request(KIND_SEARCH, 0,          $urandom,   $urandom);
    send_request(KIND_UPDATE, AMOUNT_MAX, $urandom,   AMOUNT_MAX);
    send_request(KIND_INSERT, 0,          AMOUNT_MAX, $urandom);
    send_request(KIND_INSERT, AMOUNT_MIN, AMOUNT_MIN, $urandom);
    send_request(KIND_INSERT, AMOUNT_MAX, 0,          $urandom);
    send_request(KIND_INSERT, -1,         -1,         $urandom);
    send_request(KIND_INSERT, 1,          1,          $urandom);
    send_request(KIND_INSERT, 0,          5,          $urandom);
    send_request(KIND_SEARCH, AMOUNT_MIN, $urandom,   $urandom);
    send_request(KIND_SEARCH, AMOUNT_MAX, $urandom,   $urandom);
    // saturation at both ends
    send_request(KIND_UPDATE, 0,          $urandom,   1);
    send_request(KIND_UPDATE, AMOUNT_MIN, $urandom,   -1);
    send_request(KIND_UPDATE, AMOUNT_MIN, $urandom,   AMOUNT_MAX);
    send_request(KIND_UPDATE, -1,         $urandom,   AMOUNT_MIN);
    send_request(KIND_UPDATE, 1,          $urandom,   5);
    send_request(KIND_UPDATE, AMOUNT_MAX, $urandom,   AMOUNT_MIN);
    send_request(KIND_UPDATE, AMOUNT_MAX, $urandom,   AMOUNT_MAX);
    send_request(KIND_UPDATE, 0,          $urandom,   AMOUNT_MAX);
    send_request(KIND_SEARCH, 2,          $urandom,   $urandom);
    send_request(KIND_DUMP,   $urandom,   $urandom,   $urandom);
  endtask

  task automatic test_random_mix(input int n_items);
    int                 roll;
    kind_t              kind;
    logic signed [31:0] key;
    logic signed [31:0] init;
    logic signed [31:0] delta;
    for (int i = 0; i < n_items; i++) begin
      case ((i / 40) % 4)
        0:       set_idling(0, 0);
        1:       set_idling(47, 0);
        2:       set_idling(0, 47);
        default: set_idling(32, 32);
      endcase
      roll  = $urandom_range(0, 99);
      init  = pick_amount();
      delta = $urandom;
      key   = $urandom;
      if (roll < 32) begin
        kind = KIND_INSERT;
        case ($urandom_range(0, 9))
          0, 1:    key = pick_known_key();
          2:       key = pick_known_key() + 1;
          3:       key = pick_known_key() - 1;
          default: key = $urandom;
        endcase
      end else if (roll < 55) begin
        kind = KIND_SEARCH;
        if ($urandom_range(0, 99) < 80) key = pick_known_key();
      end else if (roll < 90) begin
        kind = KIND_UPDATE;
        if ($urandom_range(0, 99) < 80) key = pick_known_key();
        case ($urandom_range(0, 3))
          0:       delta = AMOUNT_MAX;
          1:       delta = AMOUNT_MIN;
          2:       delta = $urandom_range(0, 200) - 100;
          default: delta = $urandom;
        endcase
      end else begin
        kind = KIND_DUMP;
      end
      send_request(kind, key, init, delta);
    end
  endtask

  task automatic test_full_table();
    logic signed [31:0] key;
    set_idling(32, 32);
    while (mirror_count < TABLE_DEPTH) begin
      key = $urandom;
      if (mirror_find(key) < 0) send_request(KIND_INSERT, key, pick_amount(), $urandom);
    end
    do key = $urandom; while (mirror_find(key) >= 0);
    send_request(KIND_INSERT, key, $urandom, $urandom);
    // full refusal takes precedence over a duplicate key
    send_request(KIND_INSERT, mirror_key[0], $urandom, $urandom);
    send_request(KIND_SEARCH, mirror_key[TABLE_DEPTH-1], $urandom, $urandom);
    send_request(KIND_UPDATE, mirror_key[TABLE_DEPTH-1], $urandom, $urandom);
    send_request(KIND_SEARCH, key, $urandom, $urandom);
    send_request(KIND_DUMP, $urandom, $urandom, $urandom);
  endtask

  initial begin
    in_chan.valid          = 1'b0;
    in_chan.kind           = KIND_INSERT;
    in_chan.item_key       = '0;
    in_chan.initial_amount = '0;
    in_chan.amount_delta   = '0;
    out_chan.ready         = 1'b0;
    set_idling(0, 0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_mix(330);
    test_full_table();

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (outcome_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests including %0d dumps, %0d results checked",
             requests_sent, dumps_sent, results_checked);
    $display("table filled to %0d of %0d entries, %0d inserts refused as full",
             peak_fill, TABLE_DEPTH, full_refusals);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
